// ===== rtl/iwsc_pkg.sv =====
// ----------------------------------------------------------------------------
// Interrupt and wait-state control package
// Shared types, register addresses and wait-count tables for the system
// control block and its checker.
// ----------------------------------------------------------------------------
`default_nettype none

package iwsc_pkg;

   // Item operation codes.
   typedef enum logic [1:0] {
      OP_WRITE = 2'd0,
      OP_READ  = 2'd1,
      OP_IRQ   = 2'd2,
      OP_SYNC  = 2'd3
   } op_type;

   // Power state of the system.
   typedef enum logic [1:0] {
      PS_RUN  = 2'd0,
      PS_HALT = 2'd1,
      PS_STOP = 2'd2
   } power_type;

   typedef logic [27:0] addr_type;

   // Access size codes; any code above halfword is a word access.
   localparam logic [1:0] WidthByte = 2'd0;
   localparam logic [1:0] WidthHalf = 2'd1;

   // Register byte addresses.
   localparam addr_type RegIeLo    = 28'h4000200;
   localparam addr_type RegIeHi    = 28'h4000201;
   localparam addr_type RegIfLo    = 28'h4000202;
   localparam addr_type RegIfHi    = 28'h4000203;
   localparam addr_type RegWcLo    = 28'h4000204;
   localparam addr_type RegWcHi    = 28'h4000205;
   localparam addr_type RegIme     = 28'h4000208;
   localparam addr_type RegPost    = 28'h4000300;
   localparam addr_type RegHalt    = 28'h4000301;
   localparam addr_type RegScratch = 28'h4000410;
   localparam addr_type RegMcLo    = 28'h4000800;
   localparam addr_type RegMcHi    = 28'h4000803;

   // Memory-control mirror decode.
   localparam addr_type MirrorMask  = 28'hF00FFFC;
   localparam addr_type MirrorMatch = 28'h4000800;
   localparam addr_type MirrorClear = 28'hF00FFFF;

   // Write masks and reset values.
   localparam logic [7:0]  WcHiMask     = 8'h5F;
   localparam logic [7:0]  McLoMask     = 8'h2F;
   localparam logic [7:0]  McLoReset    = 8'h20;
   localparam logic [7:0]  McHiReset    = 8'h0D;
   localparam logic [13:0] IrqWakeMask  = 14'h3080;

   // ROM regions and wait counts.
   localparam addr_type   Ws1Base      = 28'hA000000;
   localparam addr_type   Ws2Base      = 28'hC000000;
   localparam logic [4:0] SeqWaitFast  = 5'd2;
   localparam logic [4:0] Ws0SeqSlow   = 5'd3;
   localparam logic [4:0] Ws1SeqSlow   = 5'd5;
   localparam logic [4:0] Ws2SeqSlow   = 5'd9;
   localparam logic [4:0] WramWaitBase = 5'd16;

   // Non-sequential wait count for a two-bit wait-control code.
   function automatic logic [4:0] first_wait(input logic [1:0] code);
      logic [4:0] cycles;
      unique case (code)
         2'd0: cycles = 5'd5;
         2'd1: cycles = 5'd4;
         2'd2: cycles = 5'd3;
         2'd3: cycles = 5'd9;
         default: cycles = 5'd5;
      endcase
      return cycles;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/interrupt_and_wait_state_control_top.sv =====
// ----------------------------------------------------------------------------
// Interrupt and wait-state control
// Pipeline: a request is registered in the input stage, its result in the
// result register. Throughput: one item per cycle unless rsp_ready stalls,
// set by the input register feeding the single decode stage and the result register.
// Reset: synchronous, clears both stages and loads all control registers
// with their reset values (memory control 0x0D000020, power state running).
// ----------------------------------------------------------------------------
`default_nettype none

module interrupt_and_wait_state_control_top
   import iwsc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   // Request channel
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_op,
   input  wire logic [27:0] req_address,
   input  wire logic [1:0]  req_width,
   input  wire logic [31:0] req_write_data,
   input  wire logic [13:0] req_irq_bits,
   // Response channel
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [31:0]      rsp_read_data,
   output logic             rsp_irq_taken,
   output logic [4:0]       rsp_rom_first_wait,
   output logic [4:0]       rsp_rom_seq_wait,
   output logic [3:0]       rsp_sram_wait,
   output logic [5:0]       rsp_wram_wait,
   output logic [1:0]       rsp_halt_mode,
   output logic             rsp_prefetch_enable,
   output logic [1:0]       rsp_phi_select,
   output logic             rsp_wram_enabled,
   output logic             rsp_wram256_enabled
);

   // Input stage
   logic        in_valid_ff;
   op_type      op_ff;
   addr_type    addr_ff;
   logic [1:0]  width_ff;
   logic [31:0] wdata_ff;
   logic [13:0] irq_ff;

   // Control registers
   logic [13:0] ie_ff, ie_in;
   logic [13:0] if_ff, if_in;
   logic        me_ff, me_in;
   logic [15:0] wc_ff, wc_in;
   logic        post_ff, post_in;
   logic [7:0]  scratch_ff, scratch_in;
   logic [7:0]  mc_lo_ff, mc_lo_in;
   logic [7:0]  mc_hi_ff, mc_hi_in;
   power_type   ps_ff, ps_in;

   // Result stage
   logic        rsp_valid_ff;
   logic [31:0] read_data_ff, read_data_in;
   logic        taken_ff, taken_in;
   logic [4:0]  rom_first_ff, rom_first_in;
   logic [4:0]  rom_seq_ff, rom_seq_in;
   logic [3:0]  sram_ff, sram_in;
   logic [5:0]  wram_ff, wram_in;
   logic [1:0]  halt_ff;
   logic        prefetch_ff;
   logic [1:0]  phi_ff;
   logic        wram_en_ff;
   logic        wram256_ff;

   logic        advance;
   logic        is_word;
   logic        is_half;
   addr_type    rom_base;
   addr_type    reg_base;
   logic [3:0]  lane_en;
   addr_type    lane_addr [4];

   // Handshake: the input stage moves on when the result register is free
   // or is being emptied in the same cycle.
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   // Address alignment, mirror decode and byte lane enables.
   always_comb begin
      is_word  = width_ff[1];
      is_half  = (width_ff == WidthHalf);
      rom_base = {addr_ff[27:2],
                  is_word ? 1'b0 : addr_ff[1],
                  (is_word || is_half) ? 1'b0 : addr_ff[0]};
      reg_base = rom_base;
      if ((rom_base & MirrorMask) == MirrorMatch) begin
         reg_base = rom_base & MirrorClear;
      end
      lane_en = {is_word, is_word, is_word || is_half, 1'b1};
      for (int i = 0; i < 4; i++) begin
         lane_addr[i] = {reg_base[27:2], reg_base[1:0] | 2'(i)};
      end
   end

   // Register updates for the item in the input stage.
   always_comb begin
      logic [7:0] lane_data;
      ie_in      = ie_ff;
      if_in      = if_ff;
      me_in      = me_ff;
      wc_in      = wc_ff;
      post_in    = post_ff;
      scratch_in = scratch_ff;
      mc_lo_in   = mc_lo_ff;
      mc_hi_in   = mc_hi_ff;
      ps_in      = ps_ff;
      taken_in   = 1'b0;
      lane_data  = 8'h00;
      unique case (op_ff)
         OP_WRITE: begin
            for (int i = 0; i < 4; i++) begin
               lane_data = wdata_ff[8*i +: 8];
               if (lane_en[i]) begin
                  unique case (lane_addr[i])
                     RegIeLo:    ie_in[7:0]   = lane_data;
                     RegIeHi:    ie_in[13:8]  = lane_data[5:0];
                     RegIfLo:    if_in[7:0]   = if_in[7:0] & ~lane_data;
                     RegIfHi:    if_in[13:8]  = if_in[13:8] & ~lane_data[5:0];
                     RegWcLo:    wc_in[7:0]   = lane_data;
                     RegWcHi:    wc_in[15:8]  = lane_data & WcHiMask;
                     RegIme:     me_in        = lane_data[0];
                     RegPost:    post_in      = lane_data[0];
                     RegHalt:    ps_in        = lane_data[7] ? PS_STOP : PS_HALT;
                     RegScratch: scratch_in   = lane_data;
                     RegMcLo:    mc_lo_in     = lane_data & McLoMask;
                     RegMcHi:    mc_hi_in     = lane_data;
                     default: ;
                  endcase
               end
            end
         end
         OP_READ: ;
         OP_IRQ: begin
            // In stop mode a request only wakes the system.
            if (ps_ff != PS_STOP) begin
               if_in = if_ff | irq_ff;
            end else if ((irq_ff & IrqWakeMask & ie_ff) != '0) begin
               ps_in = PS_RUN;
            end
         end
         OP_SYNC: begin
            if ((ie_ff & if_ff) != '0) begin
               ps_in    = PS_RUN;
               taken_in = me_ff;
            end
         end
         default: ;
      endcase
   end

   // Read data, one byte lane at a time.
   always_comb begin
      read_data_in = '0;
      if (op_ff == OP_READ) begin
         for (int i = 0; i < 4; i++) begin
            if (lane_en[i]) begin
               unique case (lane_addr[i])
                  RegIeLo:    read_data_in[8*i +: 8] = ie_ff[7:0];
                  RegIeHi:    read_data_in[8*i +: 8] = {2'b00, ie_ff[13:8]};
                  RegIfLo:    read_data_in[8*i +: 8] = if_ff[7:0];
                  RegIfHi:    read_data_in[8*i +: 8] = {2'b00, if_ff[13:8]};
                  RegWcLo:    read_data_in[8*i +: 8] = wc_ff[7:0];
                  RegWcHi:    read_data_in[8*i +: 8] = wc_ff[15:8];
                  RegIme:     read_data_in[8*i +: 8] = {7'b0, me_ff};
                  RegPost:    read_data_in[8*i +: 8] = {7'b0, post_ff};
                  RegScratch: read_data_in[8*i +: 8] = scratch_ff;
                  RegMcLo:    read_data_in[8*i +: 8] = mc_lo_ff;
                  RegMcHi:    read_data_in[8*i +: 8] = mc_hi_ff;
                  default:    read_data_in[8*i +: 8] = 8'h00;
               endcase
            end
         end
      end
   end

   // Wait counts from the updated wait and memory control registers.
   always_comb begin
      logic [4:0] first_cnt;
      logic [4:0] seq_cnt;
      logic [4:0] sram_cnt;
      logic [4:0] wram_cnt;
      priority if (rom_base < Ws1Base) begin
         first_cnt = first_wait(wc_in[3:2]);
         seq_cnt   = wc_in[4] ? SeqWaitFast : Ws0SeqSlow;
      end else if (rom_base < Ws2Base) begin
         first_cnt = first_wait(wc_in[6:5]);
         seq_cnt   = wc_in[7] ? SeqWaitFast : Ws1SeqSlow;
      end else begin
         first_cnt = first_wait(wc_in[9:8]);
         seq_cnt   = wc_in[10] ? SeqWaitFast : Ws2SeqSlow;
      end
      // A word is two halfword accesses, the second one sequential.
      if (is_word) begin
         first_cnt = first_cnt + seq_cnt;
         seq_cnt   = {seq_cnt[3:0], 1'b0};
      end
      // A 128K boundary always restarts a non-sequential access.
      if (rom_base[16:0] == '0) begin
         seq_cnt = first_cnt;
      end
      rom_first_in = first_cnt;
      rom_seq_in   = seq_cnt;
      sram_cnt     = first_wait(wc_in[1:0]);
      sram_in      = sram_cnt[3:0];
      wram_cnt     = WramWaitBase - {1'b0, mc_hi_in[3:0]};
      wram_in      = is_word ? {wram_cnt, 1'b0} : {1'b0, wram_cnt};
   end

   // Control state: stage valids and the system registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         ie_ff        <= '0;
         if_ff        <= '0;
         me_ff        <= 1'b0;
         wc_ff        <= '0;
         post_ff      <= 1'b0;
         scratch_ff   <= '0;
         mc_lo_ff     <= McLoReset;
         mc_hi_ff     <= McHiReset;
         ps_ff        <= PS_RUN;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
            ie_ff        <= ie_in;
            if_ff        <= if_in;
            me_ff        <= me_in;
            wc_ff        <= wc_in;
            post_ff      <= post_in;
            scratch_ff   <= scratch_in;
            mc_lo_ff     <= mc_lo_in;
            mc_hi_ff     <= mc_hi_in;
            ps_ff        <= ps_in;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Input payload register.
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         op_ff    <= op_type'(req_op);
         addr_ff  <= req_address;
         width_ff <= req_width;
         wdata_ff <= req_write_data;
         irq_ff   <= req_irq_bits;
      end
   end

   // Result payload register.
   always_ff @(posedge clock) begin
      if (advance) begin
         read_data_ff <= read_data_in;
         taken_ff     <= taken_in;
         rom_first_ff <= rom_first_in;
         rom_seq_ff   <= rom_seq_in;
         sram_ff      <= sram_in;
         wram_ff      <= wram_in;
         halt_ff      <= ps_in;
         prefetch_ff  <= wc_in[14];
         phi_ff       <= wc_in[12:11];
         wram_en_ff   <= ~mc_lo_in[0];
         wram256_ff   <= mc_lo_in[5];
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_read_data       = read_data_ff;
   assign rsp_irq_taken       = taken_ff;
   assign rsp_rom_first_wait  = rom_first_ff;
   assign rsp_rom_seq_wait    = rom_seq_ff;
   assign rsp_sram_wait       = sram_ff;
   assign rsp_wram_wait       = wram_ff;
   assign rsp_halt_mode       = halt_ff;
   assign rsp_prefetch_enable = prefetch_ff;
   assign rsp_phi_select      = phi_ff;
   assign rsp_wram_enabled    = wram_en_ff;
   assign rsp_wram256_enabled = wram256_ff;

endmodule

`default_nettype wire

// ===== rtl/iwsc_checker.sv =====
// ----------------------------------------------------------------------------
// Interrupt and wait-state control checker
// Port-level assertions on the response channel, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module iwsc_checker
   import iwsc_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [31:0] rsp_read_data,
   input wire logic        rsp_irq_taken,
   input wire logic [3:0]  rsp_sram_wait,
   input wire logic [5:0]  rsp_wram_wait,
   input wire logic [1:0]  rsp_halt_mode
);

   // After reset both stages are empty, so requests are taken.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("pipeline not empty after reset");

   // A stalled result holds its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_read_data)
         && $stable(rsp_halt_mode))
      else $error("stalled result changed");

   // A taken interrupt always leaves the system running.
   a_taken_runs: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_irq_taken |-> rsp_halt_mode == PS_RUN)
      else $error("interrupt taken while not running");

   // SRAM wait count comes from the four-entry table only.
   a_sram_table: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_sram_wait == 4'd3 || rsp_sram_wait == 4'd4
         || rsp_sram_wait == 4'd5 || rsp_sram_wait == 4'd9)
      else $error("SRAM wait count out of table");

   // Work RAM wait is never zero and never above the doubled maximum.
   a_wram_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_wram_wait != 6'd0 && rsp_wram_wait <= 6'd32)
      else $error("work RAM wait count out of range");

endmodule

bind interrupt_and_wait_state_control_top iwsc_checker u_iwsc_checker (.*);

`default_nettype wire

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// Interrupt and wait-state control testbench
// Drives bus writes, bus reads, interrupt requests and sync checks into the
// system control block and checks every result field against a cycle-free
// predictor of the register file, interrupt logic and wait-count decode.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
   import iwsc_pkg::*;

   // Start of the first cartridge ROM region.
   localparam addr_type Ws0Base = 28'h8000000;
   // Non-sequential cycle counts indexed by a two-bit wait-control code.
   localparam logic [3:0][4:0] NonseqCycles = {5'd9, 5'd3, 5'd4, 5'd5};
   localparam int RandomItems = 1350;
   localparam int DrainCycles = 8;

   // One expected result transfer.
   typedef struct packed {
      logic [31:0] read_data;
      logic        irq_taken;
      logic [4:0]  rom_first_wait;
      logic [4:0]  rom_seq_wait;
      logic [3:0]  sram_wait;
      logic [5:0]  wram_wait;
      power_type   halt_mode;
      logic        prefetch_enable;
      logic [1:0]  phi_select;
      logic        wram_enabled;
      logic        wram256_enabled;
   } ctrl_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_op = '0;
   logic [27:0] req_address = '0;
   logic [1:0]  req_width = '0;
   logic [31:0] req_write_data = '0;
   logic [13:0] req_irq_bits = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [31:0] rsp_read_data;
   logic        rsp_irq_taken;
   logic [4:0]  rsp_rom_first_wait;
   logic [4:0]  rsp_rom_seq_wait;
   logic [3:0]  rsp_sram_wait;
   logic [5:0]  rsp_wram_wait;
   logic [1:0]  rsp_halt_mode;
   logic        rsp_prefetch_enable;
   logic [1:0]  rsp_phi_select;
   logic        rsp_wram_enabled;
   logic        rsp_wram256_enabled;

   // Shadow copy of the block's control state.
   logic [13:0] irq_en_shadow = '0;
   logic [13:0] irq_flag_shadow = '0;
   logic        ime_shadow = 1'b0;
   logic [15:0] waitcnt_shadow = '0;
   logic        post_shadow = 1'b0;
   logic [7:0]  scratch_shadow = '0;
   logic [31:0] memctl_shadow = {McHiReset, 16'h0000, McLoReset};
   power_type   power_shadow = PS_RUN;

   ctrl_result_type pending_results[$];
   int requests_sent = 0;
   int results_checked = 0;
   int irqs_taken = 0;
   int stop_results = 0;
   int fail_count = 0;
   bit no_idle = 1'b0;

   interrupt_and_wait_state_control_top u_top (.*);

   always #6 clock = ~clock;

   // Hard limit on the run time.
   initial begin
      #10_000_000;
      $display("TB_ERROR");
      $finish;
   end

   // Wait between transfers on either side; zero during burst stretches.
   function automatic int draw_wait();
      return no_idle ? 0 : int'($urandom_range(0, 15));
   endfunction

   // Byte write into the register map; unmapped lanes are dropped.
   function automatic void store_reg_byte(addr_type a, logic [7:0] v);
      case (a)
         RegIeLo:    irq_en_shadow[7:0] = v;
         RegIeHi:    irq_en_shadow[13:8] = v[5:0];
         RegIfLo:    irq_flag_shadow[7:0] = irq_flag_shadow[7:0] & ~v;
         RegIfHi:    irq_flag_shadow[13:8] = irq_flag_shadow[13:8] & ~v[5:0];
         RegWcLo:    waitcnt_shadow[7:0] = v;
         RegWcHi:    waitcnt_shadow[15:8] = v & WcHiMask;
         RegIme:     ime_shadow = v[0];
         RegPost:    post_shadow = v[0];
         RegHalt:    power_shadow = v[7] ? PS_STOP : PS_HALT;
         RegScratch: scratch_shadow = v;
         RegMcLo:    memctl_shadow[7:0] = v & McLoMask;
         RegMcHi:    memctl_shadow[31:24] = v;
         default: ;
      endcase
   endfunction

   // Byte read from the register map; unmapped lanes read zero.
   function automatic logic [7:0] load_reg_byte(addr_type a);
      case (a)
         RegIeLo:    return irq_en_shadow[7:0];
         RegIeHi:    return {2'b00, irq_en_shadow[13:8]};
         RegIfLo:    return irq_flag_shadow[7:0];
         RegIfHi:    return {2'b00, irq_flag_shadow[13:8]};
         RegWcLo:    return waitcnt_shadow[7:0];
         RegWcHi:    return waitcnt_shadow[15:8];
         RegIme:     return {7'b0, ime_shadow};
         RegPost:    return {7'b0, post_shadow};
         RegScratch: return scratch_shadow;
         RegMcLo:    return memctl_shadow[7:0];
         RegMcHi:    return memctl_shadow[31:24];
         default:    return 8'h00;
      endcase
   endfunction

   // Applies one item to the shadow state and returns the result it causes.
   function automatic ctrl_result_type predict_ctrl_response(op_type op, addr_type addr,
         logic [1:0] width, logic [31:0] wdata, logic [13:0] irq);
      ctrl_result_type r;
      int unsigned  nbytes;
      int unsigned  lane;
      addr_type     lane_base;
      addr_type     rom_base;
      logic [1:0]   code;
      logic [4:0]   nonseq;
      logic [4:0]   seqw;
      logic [5:0]   wram;
      r = '0;
      nbytes = (width == WidthByte) ? 1 : (width == WidthHalf) ? 2 : 4;
      lane_base = addr & ~addr_type'(nbytes - 1);
      rom_base = lane_base;
      // The memory-control group is mirrored across its 16M area.
      if ((lane_base & MirrorMask) == MirrorMatch) lane_base = lane_base & MirrorClear;

      case (op)
         OP_WRITE: begin
            for (lane = 0; lane < nbytes; lane++)
               store_reg_byte(lane_base + addr_type'(lane), wdata[8*lane +: 8]);
         end
         OP_READ: begin
            for (lane = 0; lane < nbytes; lane++)
               r.read_data[8*lane +: 8] = load_reg_byte(lane_base + addr_type'(lane));
         end
         OP_IRQ: begin
            // In stop mode a request only wakes the block, it sets no flag.
            if (power_shadow != PS_STOP) irq_flag_shadow = irq_flag_shadow | irq;
            else if ((irq & IrqWakeMask & irq_en_shadow) != '0) power_shadow = PS_RUN;
         end
         default: begin
            if ((irq_en_shadow & irq_flag_shadow) != '0) begin
               power_shadow = PS_RUN;
               r.irq_taken = ime_shadow;
            end
         end
      endcase

      // ROM wait counts use the state after the update.
      if (rom_base < Ws1Base) begin
         code = waitcnt_shadow[3:2];
         seqw = waitcnt_shadow[4] ? SeqWaitFast : Ws0SeqSlow;
      end else if (rom_base < Ws2Base) begin
         code = waitcnt_shadow[6:5];
         seqw = waitcnt_shadow[7] ? SeqWaitFast : Ws1SeqSlow;
      end else begin
         code = waitcnt_shadow[9:8];
         seqw = waitcnt_shadow[10] ? SeqWaitFast : Ws2SeqSlow;
      end
      nonseq = NonseqCycles[code];
      if (nbytes == 4) begin
         nonseq = nonseq + seqw;
         seqw = seqw + seqw;
      end
      // A 128K boundary breaks the sequential burst.
      if (rom_base[16:0] == '0) seqw = nonseq;

      wram = 6'd16 - {2'b00, memctl_shadow[27:24]};
      if (nbytes == 4) wram = wram << 1;

      r.rom_first_wait = nonseq;
      r.rom_seq_wait = seqw;
      r.sram_wait = NonseqCycles[waitcnt_shadow[1:0]][3:0];
      r.wram_wait = wram;
      r.halt_mode = power_shadow;
      r.prefetch_enable = waitcnt_shadow[14];
      r.phi_select = waitcnt_shadow[12:11];
      r.wram_enabled = ~memctl_shadow[0];
      r.wram256_enabled = memctl_shadow[5];
      return r;
   endfunction

   // Sends one item and records its expected result at the transfer.
   task automatic send_item(op_type op, addr_type addr, logic [1:0] width,
         logic [31:0] wdata, logic [13:0] irq);
      int gap;
      gap = draw_wait();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_op <= op;
      req_address <= addr;
      req_width <= width;
      req_write_data <= wdata;
      req_irq_bits <= irq;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_results.push_back(predict_ctrl_response(op, addr, width, wdata, irq));
      requests_sent++;
   endtask

   // Holds off the sender until every expected result has come back.
   task automatic wait_drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_results.size() != 0);
   endtask

   function automatic addr_type pick_address();
      addr_type a;
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4, 5: begin
            case ($urandom_range(0, 5))
               0: a = RegIeLo;
               1: a = RegWcLo;
               2: a = RegIme;
               3: a = RegPost;
               4: a = RegScratch;
               default: begin
                  a = RegMcLo;
                  if ($urandom_range(0, 1) != 0) a[23:16] = 8'($urandom());
               end
            endcase
            a = a + addr_type'($urandom_range(0, 3));
         end
         6, 7: begin
            case ($urandom_range(0, 2))
               0: a = Ws0Base;
               1: a = Ws1Base;
               default: a = Ws2Base;
            endcase
            a[20:17] = 4'($urandom());
            if ($urandom_range(0, 1) != 0) a[16:0] = 17'($urandom());
         end
         default: a = addr_type'($urandom());
      endcase
      return a;
   endfunction

   function automatic logic [13:0] pick_irq();
      return ($urandom_range(0, 1) != 0) ? 14'($urandom())
                                         : 14'(1) << $urandom_range(0, 13);
   endfunction

   task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         fail_count++;
      end
   endtask

   // Result sink with a random stall before each transfer.
   initial begin : result_sink
      int stall;
      while (reset) @(posedge clock);
      forever begin
         stall = draw_wait();
         if (stall != 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   // Compares every result transfer with the oldest expectation.
   always @(posedge clock) begin : result_check
      ctrl_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            $error("result transfer with no request outstanding");
            fail_count++;
         end else begin
            want = pending_results.pop_front();
            check_field("read_data", want.read_data, rsp_read_data);
            check_field("irq_taken", want.irq_taken, rsp_irq_taken);
            check_field("rom_first_wait", want.rom_first_wait, rsp_rom_first_wait);
            check_field("rom_seq_wait", want.rom_seq_wait, rsp_rom_seq_wait);
            check_field("sram_wait", want.sram_wait, rsp_sram_wait);
            check_field("wram_wait", want.wram_wait, rsp_wram_wait);
            check_field("halt_mode", want.halt_mode, rsp_halt_mode);
            check_field("prefetch_enable", want.prefetch_enable, rsp_prefetch_enable);
            check_field("phi_select", want.phi_select, rsp_phi_select);
            check_field("wram_enabled", want.wram_enabled, rsp_wram_enabled);
            check_field("wram256_enabled", want.wram256_enabled, rsp_wram256_enabled);
            results_checked++;
            if (want.irq_taken) irqs_taken++;
            if (want.halt_mode == PS_STOP) stop_results++;
         end
      end
   end

   // Reset values, register extremes, misaligned and mirrored accesses.
   task automatic test_register_access();
      send_item(OP_READ, RegIeLo, 2'd2, '0, '0);
      send_item(OP_WRITE, RegIeLo, 2'd2, 32'hFFFF_FFFF, '1);
      send_item(OP_WRITE, RegWcLo, WidthHalf, 32'hFFFF_FFFF, '0);
      // Width code three behaves as a word; the low address bits are dropped.
      send_item(OP_READ, 28'h4000206, 2'd3, '0, '0);
      send_item(OP_WRITE, RegScratch, WidthByte, 32'h0000_00A5, '0);
      send_item(OP_WRITE, 28'h4AB0801, WidthHalf, 32'hFFFF_FFFF, '0);
      send_item(OP_WRITE, 28'h4FF0803, WidthByte, 32'h0000_00FF, '0);
      send_item(OP_READ, 28'h4120800, 2'd2, '0, '0);
      // Unmapped space: reads return zero and writes are dropped.
      send_item(OP_READ, 28'hFFFFFFF, 2'd2, '0, '0);
      send_item(OP_WRITE, 28'h0000000, 2'd2, 32'hFFFF_FFFF, '0);
   endtask

   // Halt, stop, wake-up and the taken / not-taken sync cases.
   task automatic test_interrupts();
      send_item(OP_WRITE, RegIme, WidthByte, 32'h0000_0001, '0);
      send_item(OP_WRITE, RegPost, 2'd2, 32'h0000_0001, '0);
      send_item(OP_IRQ, RegIeLo, WidthByte, '0, 14'h3FFF);
      send_item(OP_SYNC, RegIeLo, WidthByte, '0, '0);
      send_item(OP_WRITE, RegIfLo, WidthHalf, 32'h0000_FFFF, '0);
      // Sync with nothing pending leaves the state alone.
      send_item(OP_SYNC, RegIeLo, WidthByte, '0, '0);
      send_item(OP_WRITE, RegHalt, WidthByte, 32'h0000_0080, '0);
      // A request in stop mode only wakes on an enabled wake source.
      send_item(OP_IRQ, RegIeLo, WidthByte, '0, 14'h0001);
      send_item(OP_WRITE, RegIeLo, WidthHalf, 32'h0000_1000, '0);
      send_item(OP_IRQ, RegIeLo, WidthByte, '0, 14'h1000);
      send_item(OP_IRQ, RegIeLo, WidthByte, '0, 14'h1000);
      send_item(OP_WRITE, RegIme, WidthByte, 32'h0000_0000, '0);
      send_item(OP_SYNC, RegIeLo, WidthByte, '0, '0);
   endtask

   // ROM region boundaries and the widest work-RAM wait.
   task automatic test_wait_states();
      send_item(OP_WRITE, RegWcLo, WidthHalf, 32'h0000_0000, '0);
      send_item(OP_WRITE, RegMcHi, WidthByte, 32'h0000_0000, '0);
      send_item(OP_READ, Ws0Base, 2'd2, '0, '0);
      send_item(OP_READ, 28'h9FFFFFE, WidthHalf, '0, '0);
      send_item(OP_READ, 28'hA020000, 2'd2, '0, '0);
      send_item(OP_READ, 28'hC000002, WidthByte, '0, '0);
   endtask

   // Random traffic: noise items mixed with enable / request / sync sequences.
   task automatic test_random_traffic();
      int  sent;
      bit  paused;
      sent = 0;
      paused = 1'b0;
      while (sent < RandomItems) begin
         no_idle = ((sent / 150) % 4) == 3;
         if (!paused && sent >= RandomItems / 2) begin
            wait_drain();
            paused = 1'b1;
         end
         if ($urandom_range(0, 3) == 0) begin
            send_item(OP_WRITE, RegIeLo, WidthHalf, $urandom(), '0);
            send_item(OP_WRITE, RegIme, WidthByte, $urandom(), '0);
            send_item(OP_IRQ, pick_address(), 2'($urandom()), $urandom(), pick_irq());
            send_item(OP_SYNC, pick_address(), 2'($urandom()), $urandom(), pick_irq());
            sent += 4;
         end else begin
            send_item(op_type'($urandom_range(0, 3)), pick_address(), 2'($urandom()),
                      $urandom(), pick_irq());
            sent++;
         end
      end
      no_idle = 1'b0;
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_register_access();
      test_interrupts();
      test_wait_states();
      test_random_traffic();
      wait_drain();
      repeat (DrainCycles) @(posedge clock);
      $display("Sent %0d requests (writes, reads, interrupt requests, syncs) and checked %0d results.",
               requests_sent, results_checked);
      $display("Saw %0d interrupts taken and %0d results in stop mode.", irqs_taken, stop_results);
      if (fail_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

// ===== interrupt_and_wait_state_control_top.f =====
rtl/iwsc_pkg.sv
rtl/interrupt_and_wait_state_control_top.sv
rtl/iwsc_checker.sv
sim/tb_top.sv
